// ===== rtl/sil_pkg.sv =====
// Types and codes shared by the sorted insertion list.
// No dependencies; imported by sil_cell and sorted_insertion_list_top.
package sil_pkg;

   localparam int ENTRY_W = 32;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [1:0] KIND_INSERTED = 2'd0;
   localparam logic [1:0] KIND_DROPPED  = 2'd1;
   localparam logic [1:0] KIND_ENTRY    = 2'd2;
   localparam logic [1:0] KIND_EMPTY    = 2'd3;

   typedef struct packed {
      logic                      operation;
      logic signed [ENTRY_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [ENTRY_W-1:0] entry;
      logic                      last;
   } rsp_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic                      insert;
      logic                      rotate;
      logic signed [ENTRY_W-1:0] value;
   } sil_cell_ctrl_type;

endpackage

// ===== rtl/sil_cell.sv =====
// One slot of the sorted list: holds a value, compares it against the
// broadcast insert value and shifts with its neighbors. Uses sil_pkg.
module sil_cell
   import sil_pkg::*;
(
   input  logic                      clock,
   input  sil_cell_ctrl_type         ctrl,
   input  logic                      occupied,
   input  logic                      is_tail,
   input  logic                      prev_less,
   input  logic signed [ENTRY_W-1:0] prev_entry,
   input  logic signed [ENTRY_W-1:0] next_entry,
   input  logic signed [ENTRY_W-1:0] head_entry,
   output logic                      less,
   output logic signed [ENTRY_W-1:0] entry
);

   logic signed [ENTRY_W-1:0] entry_ff;
   logic signed [ENTRY_W-1:0] entry_in;

   assign less  = occupied && (entry_ff < ctrl.value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.insert) begin
         // smaller values stay put; the first slot not smaller takes the value,
         // the ones behind it shift up by one
         if (!less) begin
            entry_in = prev_less ? ctrl.value : prev_entry;
         end
      end else if (ctrl.rotate) begin
         // readout walks the list through slot 0 and wraps the head to the tail
         entry_in = is_tail ? head_entry : next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/sorted_insertion_list_top.sv =====
// Sorted insertion list, top level: request/response handshake, count,
// readout control and the chain of sil_cell slots. Uses sil_pkg.
//
//   channel   dir   payload    handshake
//   req_      in    req_type   req_valid / req_stall
//   rsp_      out   rsp_type   rsp_valid / rsp_stall
//
// On an insert every cell compares in parallel and shifts in place.
// On a read of n entries the chain rotates one slot per beat
// through cell 0 and is back in order after the last beat.
// Reset clears the count and handshake state; slot contents are left as they are.
// A stalled response holds the chain and the request side.
module sorted_insertion_list_top
   import sil_pkg::*;
#(
   parameter int LIST_DEPTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic              out_ready;
   logic              req_accept;
   logic              full;
   logic              load;
   sil_cell_ctrl_type ctrl;

   logic signed [ENTRY_W-1:0] entry_w [LIST_DEPTH];
   logic                      less_w  [LIST_DEPTH];

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = busy_ff || !out_ready;
   assign req_accept = req_valid && !req_stall;
   assign full       = (count_ff == CNT_W'(LIST_DEPTH));

   assign ctrl.insert = req_accept && (req_data.operation == OP_INSERT) && !full;
   assign ctrl.rotate = busy_ff && out_ready;
   assign ctrl.value  = req_data.value;

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic                      prev_less;
      logic signed [ENTRY_W-1:0] prev_entry;
      logic signed [ENTRY_W-1:0] next_entry;

      if (i == 0) begin : g_head
         assign prev_less  = 1'b1;
         assign prev_entry = req_data.value;
      end else begin : g_body
         assign prev_less  = less_w[i-1];
         assign prev_entry = entry_w[i-1];
      end

      if (i == LIST_DEPTH - 1) begin : g_end
         assign next_entry = entry_w[0];
      end else begin : g_mid
         assign next_entry = entry_w[i+1];
      end

      sil_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (CNT_W'(i) < count_ff),
         .is_tail    (CNT_W'(i + 1) == count_ff),
         .prev_less  (prev_less),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .head_entry (entry_w[0]),
         .less       (less_w[i]),
         .entry      (entry_w[i])
      );
   end

   always_comb begin
      count_in    = count_ff;
      left_in     = left_ff;
      busy_in     = busy_ff;
      load        = 1'b0;
      rsp_data_in = rsp_data_ff;

      priority if (ctrl.rotate) begin
         load              = 1'b1;
         rsp_data_in.kind  = KIND_ENTRY;
         rsp_data_in.entry = entry_w[0];
         rsp_data_in.last  = (left_ff == CNT_W'(1));
         left_in           = left_ff - CNT_W'(1);
         busy_in           = (left_ff != CNT_W'(1));
      end else if (req_accept) begin
         if (req_data.operation == OP_INSERT) begin
            load              = 1'b1;
            rsp_data_in.kind  = full ? KIND_DROPPED : KIND_INSERTED;
            rsp_data_in.entry = req_data.value;
            rsp_data_in.last  = 1'b1;
            if (!full) begin
               count_in = count_ff + CNT_W'(1);
            end
         end else if (count_ff == '0) begin
            load              = 1'b1;
            rsp_data_in.kind  = KIND_EMPTY;
            rsp_data_in.entry = '0;
            rsp_data_in.last  = 1'b1;
         end else begin
            busy_in = 1'b1;
            left_in = count_ff;
         end
      end else begin
         load = 1'b0;
      end

      rsp_valid_in = out_ready ? load : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         left_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         left_ff      <= left_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== dv/sorted_insertion_list_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_insertion_list_top: a queue-based model of the
// ascending list predicts every result beat. Depends on sil_pkg and the RTL top only.
module sorted_insertion_list_top_tb;
   import sil_pkg::*;

   localparam int LIST_DEPTH = 32;

   typedef logic signed [ENTRY_W-1:0] word_type;

   localparam word_type WORD_MIN = 32'h8000_0000;
   localparam word_type WORD_MAX = 32'h7fff_ffff;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Model of the stored list and the beats it should produce.
   word_type sorted_q[$];
   rsp_type  expect_q[$];

   int  errors = 0;
   int  insert_count = 0;
   int  drop_count = 0;
   int  read_count = 0;
   int  beat_count = 0;
   bit  quiet = 1'b1;
   int  hold_req = 0;
   int  hold_left = 0;
   int  stall_left = 0;

   sorted_insertion_list_top #(
      .LIST_DEPTH(LIST_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   // Mostly short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic rsp_type make_beat(logic [1:0] kind, word_type entry, logic last);
      rsp_type b;
      b.kind  = kind;
      b.entry = entry;
      b.last  = last;
      return b;
   endfunction

   function automatic void predict_list(req_type req);
      int pos;
      pos = 0;
      if (req.operation == OP_INSERT) begin
         if (sorted_q.size() >= LIST_DEPTH) begin
            expect_q.push_back(make_beat(KIND_DROPPED, req.value, 1'b1));
            drop_count++;
         end else begin
            // New value goes ahead of the first entry that is not smaller.
            while (pos < sorted_q.size() && sorted_q[pos] < req.value) pos++;
            sorted_q.insert(pos, req.value);
            expect_q.push_back(make_beat(KIND_INSERTED, req.value, 1'b1));
         end
         insert_count++;
      end else begin
         if (sorted_q.size() == 0) begin
            expect_q.push_back(make_beat(KIND_EMPTY, '0, 1'b1));
         end else begin
            foreach (sorted_q[i])
               expect_q.push_back(make_beat(KIND_ENTRY, sorted_q[i], i == sorted_q.size() - 1));
         end
         read_count++;
      end
   endfunction

   function automatic void check_beat(rsp_type got);
      rsp_type want;
      if (expect_q.size() == 0) begin
         $display("%0t: unexpected beat: expected none, actual kind=%0d entry=%0d last=%0b",
                  $time, got.kind, got.entry, got.last);
         errors++;
         return;
      end
      want = expect_q.pop_front();
      beat_count++;
      if (got.kind !== want.kind) begin
         $display("%0t: kind mismatch: expected %0d, actual %0d", $time, want.kind, got.kind);
         errors++;
      end
      if (got.entry !== want.entry) begin
         $display("%0t: entry mismatch: expected %0d, actual %0d", $time, want.entry,
                  got.entry);
         errors++;
      end
      if (got.last !== want.last) begin
         $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, got.last);
         errors++;
      end
   endfunction

   // Request side is predicted before the result side is checked in the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predict_list(req_data);
         if (rsp_valid && !rsp_stall) check_beat(rsp_data);
      end
   end

   // Receiver stall: long hold-off on request, none while quiet, otherwise random runs.
   always @(posedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left = pick_gap();
      end
   end

   // Valid is left high after the beat; the next call either keeps it or opens a gap.
   task automatic send_item(logic op, word_type val);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.operation <= op;
      req_data.value     <= val;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expect_q.size() != 0) @(posedge clock);
   endtask

   function automatic word_type rand_value();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0, 1, 2, 3: return $urandom;
         4, 5:       return $signed($urandom_range(0, 15)) - 8;
         6:          return (sorted_q.size() != 0) ?
                            sorted_q[$urandom_range(0, sorted_q.size() - 1)] : word_type'(0);
         7:          return ($urandom_range(0, 1) != 0) ? WORD_MIN : WORD_MAX;
         8:          return ($urandom_range(0, 1) != 0) ? WORD_MIN + 1 : WORD_MAX - 1;
         default:    return ($urandom_range(0, 1) != 0) ? word_type'(-1) : word_type'(0);
      endcase
   endfunction

   task automatic test_empty_read();
      send_item(OP_READ, 32'h5a5a_a5a5);
      wait_drained();
   endtask

   // Head, tail, middle, duplicates and the signed extremes.
   task automatic test_ordering();
      send_item(OP_INSERT, 0);
      send_item(OP_INSERT, -5);
      send_item(OP_INSERT, 100);
      send_item(OP_INSERT, 7);
      send_item(OP_INSERT, 7);
      send_item(OP_INSERT, -5);
      send_item(OP_READ, 0);
      send_item(OP_INSERT, WORD_MAX);
      send_item(OP_INSERT, WORD_MIN);
      send_item(OP_INSERT, WORD_MIN + 1);
      send_item(OP_INSERT, -1);
      send_item(OP_READ, WORD_MAX);
      send_item(OP_READ, WORD_MIN);
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering, then everything drains.
   task automatic test_backpressure();
      quiet    = 1'b1;
      hold_req = 200;
      for (int i = 0; i < 16; i++) begin
         if (i % 5 == 4) send_item(OP_READ, $urandom);
         else send_item(OP_INSERT, $signed($urandom_range(0, 255)) - 128);
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < 150; i++) begin
         if (i % 30 == 0) quiet = ((i / 30) % 3 == 2);
         if ($urandom_range(0, 4) == 0) send_item(OP_READ, $urandom);
         else send_item(OP_INSERT, rand_value());
      end
      quiet = 1'b0;
      wait_drained();
   endtask

   // Top up to full, then inserts must be dropped and the full list read back.
   task automatic test_fill_and_drop();
      int need;
      need = LIST_DEPTH - sorted_q.size();
      for (int i = 0; i < need; i++) send_item(OP_INSERT, rand_value());
      send_item(OP_INSERT, WORD_MIN);
      send_item(OP_INSERT, WORD_MAX);
      send_item(OP_INSERT, $urandom);
      send_item(OP_READ, 0);
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_read();
      test_ordering();
      test_backpressure();
      quiet = 1'b0;
      test_random_traffic();
      test_fill_and_drop();
      repeat (LIST_DEPTH + 4) @(posedge clock);
      if (expect_q.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, expect_q.size());
         errors++;
      end
      $display("Sent %0d inserts (%0d dropped on a full list) and %0d reads;", insert_count,
               drop_count, read_count);
      $display("checked %0d result beats under random gaps, stalls and a long hold-off.",
               beat_count);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sil_pkg.sv
rtl/sil_cell.sv
rtl/sorted_insertion_list_top.sv
dv/sorted_insertion_list_top_tb.sv
